>>> sv/mlprq_pkg.sv
package mlprq_pkg;

  // Sizing of the scheduler.
  localparam int NUM_LEVELS   = 64;
  localparam int LEVEL_DEPTH  = 16;
  localparam int TASK_ID_BITS = 8;

  // Derived widths.
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SUM_W  = $clog2(2 * LEVEL_DEPTH);
  localparam int ID_W   = TASK_ID_BITS;
  localparam int QADR_W = LVL_W + PTR_W;
  localparam int QDEPTH = NUM_LEVELS * (2 ** PTR_W);

  // Command codes of an input word.
  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_SCHED = 1'b1
  } cmd_t;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PUSH = 4'b0010,
    ST_POP  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Per-level queue descriptor held in the descriptor memory.
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] cnt;
  } meta_t;

  typedef logic [NUM_LEVELS-1:0] map_t;

  // Lowest set bit of the non-empty map.
  function automatic logic [LVL_W-1:0] first_level(input map_t m);
    logic [LVL_W-1:0] idx;
    idx = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = LVL_W'(i);
      end
    end
    return idx;
  endfunction

  // One-hot mask for a level.
  function automatic map_t level_bit(input logic [LVL_W-1:0] lvl);
    map_t one;
    one = map_t'(1);
    return one << lvl;
  endfunction

endpackage

>>> sv/mlprq_ram.sv
module mlprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/multilevel_priority_ready_queue.sv
// Add: the word passes through the push state and the result strobe is registered
// from it. For either command a new word is taken only once the block is idle again.
// Schedule: push, pop and output states in turn, or push alone when disabled or empty;
// pop and output cover the descriptor memory read-modify-write and the store read.
// Reset clears all levels at once through per-level valid bits, so no clearing pass
// is needed and a word can be accepted as soon as reset is released. Results cannot stall.
module multilevel_priority_ready_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [7:0]  in_task_id,
  input  logic [5:0]  in_priority_req,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_strobe,
  output logic        out_next_valid,
  output logic [7:0]  out_next_task_id,
  output logic [5:0]  out_next_priority,
  output logic [1:0]  out_status
);
  import mlprq_pkg::*;

  // Control state.
  state_t           state_r, state_nxt;
  logic             en_r, en_nxt;
  map_t             map_r, map_nxt;
  map_t             meta_vld_r, meta_vld_nxt;
  logic             run_vld_r, run_vld_nxt;
  logic             out_strobe_r, out_strobe_nxt;

  // Payload state.
  logic [ID_W-1:0]  run_id_r, run_id_nxt;
  logic [LVL_W-1:0] run_lvl_r, run_lvl_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [LVL_W-1:0] plvl_r, plvl_nxt;
  logic             push_en_r, push_en_nxt;
  logic             drop_r, drop_nxt;
  logic [LVL_W-1:0] sel_r, sel_nxt;
  logic             fwd_r, fwd_nxt;
  meta_t            fwd_meta_r, fwd_meta_nxt;
  logic             meta_rv_r, meta_rv_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic [LVL_W-1:0] out_lvl_r, out_lvl_nxt;
  stat_t            out_stat_r, out_stat_nxt;

  // Memory ports.
  logic               meta_we;
  logic [LVL_W-1:0]   meta_waddr, meta_raddr;
  meta_t              meta_wdata;
  logic [$bits(meta_t)-1:0] meta_rdata;
  logic               q_we;
  logic [QADR_W-1:0]  q_waddr, q_raddr;
  logic [ID_W-1:0]    q_rdata;

  // Datapath signals.
  logic [LVL_W-1:0] in_lvl;
  meta_t            meta_rd, push_meta, pop_meta, pop_upd;
  logic             lvl_full, push_ok, drop;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail_slot;
  map_t             map_push;
  logic [LVL_W-1:0] sel_lvl;

  // Descriptor memory: head and count for each level.
  mlprq_ram #(.WIDTH($bits(meta_t)), .DEPTH(NUM_LEVELS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // Task store: one ring of slots for each level.
  mlprq_ram #(.WIDTH(ID_W), .DEPTH(QDEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (id_r),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Requested level saturates at the last level.
  assign in_lvl = (int'(in_priority_req) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                       : LVL_W'(in_priority_req);

  // A level that was never written reads as empty with head zero.
  assign meta_rd = meta_rv_r ? meta_t'(meta_rdata) : '0;

  // Tail slot and outcome of the push.
  assign lvl_full  = (meta_rd.cnt == CNT_W'(LEVEL_DEPTH));
  assign push_ok   = push_en_r && !lvl_full;
  assign drop      = push_en_r && lvl_full;
  assign tail_sum  = SUM_W'(meta_rd.head) + SUM_W'(meta_rd.cnt);
  assign tail_slot = (tail_sum >= SUM_W'(LEVEL_DEPTH)) ? PTR_W'(tail_sum - SUM_W'(LEVEL_DEPTH))
                                                       : PTR_W'(tail_sum);
  assign push_meta.head = meta_rd.head;
  assign push_meta.cnt  = meta_rd.cnt + CNT_W'(1);
  assign q_waddr  = {plvl_r, tail_slot};

  // Level selection sees the task that is requeued in the same command.
  assign map_push = push_ok ? (map_r | level_bit(plvl_r)) : map_r;
  assign sel_lvl  = first_level(map_push);

  // Pop takes the forwarded descriptor when the push just wrote the same level.
  assign pop_meta     = fwd_r ? fwd_meta_r : meta_rd;
  assign pop_upd.head = (pop_meta.head == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                                                                   : pop_meta.head + PTR_W'(1);
  assign pop_upd.cnt  = pop_meta.cnt - CNT_W'(1);
  assign q_raddr      = {sel_r, pop_meta.head};

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt      = state_r;
    en_nxt         = en_r;
    map_nxt        = map_r;
    meta_vld_nxt   = meta_vld_r;
    run_vld_nxt    = run_vld_r;
    run_id_nxt     = run_id_r;
    run_lvl_nxt    = run_lvl_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    plvl_nxt       = plvl_r;
    push_en_nxt    = push_en_r;
    drop_nxt       = drop_r;
    sel_nxt        = sel_r;
    fwd_nxt        = fwd_r;
    fwd_meta_nxt   = fwd_meta_r;
    out_strobe_nxt = 1'b0;
    out_vld_nxt    = out_vld_r;
    out_id_nxt     = out_id_r;
    out_lvl_nxt    = out_lvl_r;
    out_stat_nxt   = out_stat_r;
    meta_we        = 1'b0;
    meta_waddr     = plvl_r;
    meta_wdata     = push_meta;
    meta_raddr     = in_lvl;
    q_we           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt     = cmd_t'(in_command);
          // A schedule requeues the running task, an add stores the new one.
          id_nxt      = (cmd_nxt == CMD_ADD) ? ID_W'(in_task_id) : run_id_r;
          plvl_nxt    = (cmd_nxt == CMD_ADD) ? in_lvl : run_lvl_r;
          push_en_nxt = (cmd_nxt == CMD_ADD) || run_vld_r;
          meta_raddr  = plvl_nxt;
          state_nxt   = ST_PUSH;
        end
      end

      ST_PUSH: begin
        // Append at the tail of the level unless it is full.
        map_nxt  = map_push;
        drop_nxt = drop;
        if (push_ok) begin
          meta_we = 1'b1;
          q_we    = 1'b1;
        end
        if (cmd_r == CMD_ADD) begin
          out_strobe_nxt = 1'b1;
          out_vld_nxt    = 1'b0;
          out_id_nxt     = '0;
          out_lvl_nxt    = '0;
          out_stat_nxt   = drop ? STAT_FULL : STAT_OK;
          state_nxt      = ST_IDLE;
        end else begin
          run_vld_nxt = 1'b0;
          if (en_r && (map_push != '0)) begin
            meta_raddr   = sel_lvl;
            sel_nxt      = sel_lvl;
            fwd_nxt      = push_ok && (sel_lvl == plvl_r);
            fwd_meta_nxt = push_meta;
            state_nxt    = ST_POP;
          end else begin
            out_strobe_nxt = 1'b1;
            out_vld_nxt    = 1'b0;
            out_id_nxt     = '0;
            out_lvl_nxt    = '0;
            out_stat_nxt   = drop ? STAT_FULL : STAT_EMPTY;
            state_nxt      = ST_IDLE;
          end
        end
      end

      ST_POP: begin
        // Advance the head; the store read of the old head is under way.
        meta_we    = 1'b1;
        meta_waddr = sel_r;
        meta_wdata = pop_upd;
        if (pop_upd.cnt == '0) begin
          map_nxt = map_r & ~level_bit(sel_r);
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        // The popped task becomes the running task.
        run_vld_nxt    = 1'b1;
        run_id_nxt     = q_rdata;
        run_lvl_nxt    = sel_r;
        out_strobe_nxt = 1'b1;
        out_vld_nxt    = 1'b1;
        out_id_nxt     = q_rdata;
        out_lvl_nxt    = sel_r;
        out_stat_nxt   = drop_r ? STAT_FULL : STAT_OK;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Any descriptor write makes its level valid.
    if (meta_we) begin
      meta_vld_nxt = meta_vld_r | level_bit(meta_waddr);
    end

    // Configuration write.
    if (cfg_we) begin
      en_nxt = cfg_wdata;
    end
  end

  // Valid bit follows the descriptor read.
  assign meta_rv_nxt = meta_vld_r[meta_raddr];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      en_r         <= 1'b0;
      map_r        <= '0;
      meta_vld_r   <= '0;
      run_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      en_r         <= en_nxt;
      map_r        <= map_nxt;
      meta_vld_r   <= meta_vld_nxt;
      run_vld_r    <= run_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    run_id_r   <= run_id_nxt;
    run_lvl_r  <= run_lvl_nxt;
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    plvl_r     <= plvl_nxt;
    push_en_r  <= push_en_nxt;
    drop_r     <= drop_nxt;
    sel_r      <= sel_nxt;
    fwd_r      <= fwd_nxt;
    fwd_meta_r <= fwd_meta_nxt;
    meta_rv_r  <= meta_rv_nxt;
    out_vld_r  <= out_vld_nxt;
    out_id_r   <= out_id_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // Outputs.
  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_next_valid    = out_vld_r;
  assign out_next_task_id  = 8'(out_id_r);
  assign out_next_priority = 6'(out_lvl_r);
  assign out_status        = out_stat_r;

`ifndef ASSERT_OFF
  // A result word only follows the push step or the output step.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_PUSH || $past(state_r) == ST_OUT))
    else $error("result strobe without a finishing step");

  // A selected task never comes with the no-task status.
  a_valid_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_next_valid) |-> (out_status != STAT_EMPTY))
    else $error("selected task reported with no-task status");

  // The popped level is never empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> (pop_meta.cnt != '0))
    else $error("pop from an empty level");

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start the sequencer");
`endif

endmodule
